@@ src/angular_accel_matrix_stream_defines.svh @@
// Assertion macros shared by the checker files of the angular acceleration matrix block.
`ifndef ANGULAR_ACCEL_MATRIX_STREAM_DEFINES_SVH
`define ANGULAR_ACCEL_MATRIX_STREAM_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define AAMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define AAMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Property checked at every edge, reset included.
`define AAMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/aams_pkg.sv @@
// Shared types, constants and helper functions for the angular acceleration matrix block.
package aams_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int INV_W            = 24;
  localparam int DW_W             = 32;
  localparam int ENT_W            = 40;
  localparam int NUM_ENT          = 9;
  localparam int WIDE_W           = 66;
  localparam int FILL_W           = 3;
  localparam int CFG_AW           = 3;
  localparam int CFG_DW           = 32;

  localparam logic [INV_W-1:0]  INV_RESET    = 24'd5461;
  localparam logic [FILL_W-1:0] FILL_FULL    = 3'd4;
  localparam logic              CFG_IDX_INV  = 1'b0;

  typedef logic signed [WIDE_W-1:0]     wide_t;
  typedef logic [NUM_ENT-1:0][ENT_W-1:0] mat_t;

  typedef struct packed {
    logic shift;
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Clamp a wide signed value to the signed 40-bit entry range.
  function automatic logic [ENT_W-1:0] sat_ent(input wide_t v);
    logic [ENT_W-1:0] r;
    if ((&v[WIDE_W-1:ENT_W-1]) || !(|v[WIDE_W-1:ENT_W-1])) begin
      r = v[ENT_W-1:0];
    end else begin
      r = {v[WIDE_W-1], {(ENT_W-1){~v[WIDE_W-1]}}};
    end
    return r;
  endfunction

endpackage

@@ src/aams_lane.sv @@
// One axis lane: sample history, five-point stencil, scaling, rounding and the two rate products.
module aams_lane #(
  parameter int SAMPLE_WIDTH = aams_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  aams_pkg::stage_en_t                   en_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  logic [aams_pkg::INV_W-1:0]            inv_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        nb_w_i,
  output logic signed [SAMPLE_WIDTH-1:0]        w_o,
  output logic signed [aams_pkg::DW_W-1:0]      dw_o,
  output logic signed [2*SAMPLE_WIDTH-1:0]      sq_o,
  output logic signed [2*SAMPLE_WIDTH-1:0]      cr_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int STW = SW + 5;
  localparam int PW  = SW + 30;
  localparam int QW  = PW - 5;
  localparam int SQW = 2 * SW;
  localparam int DWW = aams_pkg::DW_W;

  localparam logic signed [PW-1:0] RND_HALF = PW'(16);

  logic signed [SW-1:0]  hist_r [4];
  logic signed [STW-1:0] st_r;
  logic signed [STW-1:0] st_nxt;
  logic signed [SW-1:0]  w1_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  prod_nxt;
  logic signed [SQW-1:0] sq2_r;
  logic signed [SQW-1:0] cr2_r;
  logic signed [SQW-1:0] sq3_r;
  logic signed [SQW-1:0] cr3_r;
  logic signed [DWW-1:0] dw_r;
  logic signed [DWW-1:0] dw_nxt;
  logic signed [PW-1:0]  rnd;
  logic signed [QW-1:0]  q;
  logic signed [STW-1:0] e0, e1, e3, e4;

  always_comb begin
    e0     = STW'(hist_r[0]);
    e1     = STW'(hist_r[1]);
    e3     = STW'(hist_r[3]);
    e4     = STW'(sample_i);
    st_nxt = e0 - (e1 <<< 3) + (e3 <<< 3) - e4;
  end

  assign prod_nxt = PW'(st_r) * PW'($signed({1'b0, inv_i}));

  // Round half up, then clamp to the signed 32-bit range.
  always_comb begin
    rnd = prod_r + RND_HALF;
    q   = rnd[PW-1:5];
    if ((&q[QW-1:DWW-1]) || !(|q[QW-1:DWW-1])) begin
      dw_nxt = q[DWW-1:0];
    end else begin
      dw_nxt = {q[QW-1], {(DWW-1){~q[QW-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en_i.shift) begin
      hist_r[0] <= hist_r[1];
      hist_r[1] <= hist_r[2];
      hist_r[2] <= hist_r[3];
      hist_r[3] <= sample_i;
    end
    if (en_i.s1) begin
      st_r <= st_nxt;
      w1_r <= hist_r[2];
    end
    if (en_i.s2) begin
      prod_r <= prod_nxt;
      sq2_r  <= SQW'(w1_r) * SQW'(w1_r);
      cr2_r  <= SQW'(w1_r) * SQW'(nb_w_i);
    end
    if (en_i.s3) begin
      dw_r  <= dw_nxt;
      sq3_r <= sq2_r;
      cr3_r <= cr2_r;
    end
  end

  assign w_o  = w1_r;
  assign dw_o = dw_r;
  assign sq_o = sq3_r;
  assign cr_o = cr3_r;

endmodule

@@ src/aams_merge.sv @@
// Merging stage: combines the three lanes into the nine clamped matrix entries.
module aams_merge #(
  parameter int SAMPLE_WIDTH = aams_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                load_i,
  input  logic signed [aams_pkg::DW_W-1:0]    dw_i [3],
  input  logic signed [2*SAMPLE_WIDTH-1:0]    sq_i [3],
  input  logic signed [2*SAMPLE_WIDTH-1:0]    cr_i [3],
  output aams_pkg::mat_t                      mat_o
);

  aams_pkg::mat_t mat_r;
  aams_pkg::mat_t mat_nxt;
  aams_pkg::wide_t dx, dy, dz, sx, sy, sz, cxy, cyz, czx;

  always_comb begin
    dx  = aams_pkg::wide_t'(dw_i[0]);
    dy  = aams_pkg::wide_t'(dw_i[1]);
    dz  = aams_pkg::wide_t'(dw_i[2]);
    sx  = aams_pkg::wide_t'(sq_i[0]);
    sy  = aams_pkg::wide_t'(sq_i[1]);
    sz  = aams_pkg::wide_t'(sq_i[2]);
    cxy = aams_pkg::wide_t'(cr_i[0]);
    cyz = aams_pkg::wide_t'(cr_i[1]);
    czx = aams_pkg::wide_t'(cr_i[2]);
    mat_nxt[0] = aams_pkg::sat_ent(-(sy + sz));
    mat_nxt[1] = aams_pkg::sat_ent(cxy - dz);
    mat_nxt[2] = aams_pkg::sat_ent(dy + czx);
    mat_nxt[3] = aams_pkg::sat_ent(dz + cxy);
    mat_nxt[4] = aams_pkg::sat_ent(-(sx + sz));
    mat_nxt[5] = aams_pkg::sat_ent(cyz - dx);
    mat_nxt[6] = aams_pkg::sat_ent(czx - dy);
    mat_nxt[7] = aams_pkg::sat_ent(dx + cyz);
    mat_nxt[8] = aams_pkg::sat_ent(-(sx + sy));
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      mat_r <= mat_nxt;
    end
  end

  assign mat_o = mat_r;

endmodule

@@ src/angular_accel_matrix_stream.sv @@
// Top level of the angular acceleration matrix block: handshakes, register port, lanes and merge.
//
//  Channel | Direction | Word contents
//  in_     | slave     | tdata: rate_x, rate_y, rate_z; tuser: restart
//  out_    | master    | tdata: m00 .. m22, 40 bits each, row by row
//  cfg_    | APB       | register 0 at byte address 0: inv_twelve_dt
//
// One input word can be taken every clock cycle while the pipeline is not stalled. A word
// that completes a run of five samples gives a matrix that passes through the stencil,
// multiplier, rounding and merge stages, the last of which is the output register.
// Reset is synchronous and active low; it empties the history and the pipeline and
// loads inv_twelve_dt with its default.
// Each stage moves on when the stage after it is empty or moving, so a stalled output
// still lets words enter until every stage holds one.
module angular_accel_matrix_stream #(
  parameter int SAMPLE_WIDTH = aams_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: rate_x, rate_y, rate_z from bit 0 up, zero padding to whole bytes
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  in_tdata,
  // in_tuser: restart
  input  logic [0:0]                           in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
  output logic [aams_pkg::NUM_ENT*aams_pkg::ENT_W-1:0] out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [aams_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [aams_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [aams_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int SW = SAMPLE_WIDTH;

  logic [aams_pkg::INV_W-1:0]  inv_r;
  logic [aams_pkg::FILL_W-1:0] fill_r;
  logic [aams_pkg::FILL_W-1:0] fill_nxt;
  logic v1_r, v2_r, v3_r, ov_r;
  logic v1_nxt;
  logic e1, e2, e3, e4;
  logic in_acc;
  logic cfg_wr;
  aams_pkg::stage_en_t en;

  logic signed [SW-1:0]               w_cent [3];
  logic signed [aams_pkg::DW_W-1:0]   dw     [3];
  logic signed [2*SW-1:0]             sq     [3];
  logic signed [2*SW-1:0]             cr     [3];
  aams_pkg::mat_t                     mat;

  // Register port: writes complete in the access phase, no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    if (cfg_paddr[2] == aams_pkg::CFG_IDX_INV) begin
      cfg_prdata = aams_pkg::CFG_DW'(inv_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // Stage enables, taken from the output end backwards.
  assign e4        = !ov_r || out_tready;
  assign e3        = !v3_r || e4;
  assign e2        = !v2_r || e3;
  assign e1        = !v1_r || e2;
  assign in_tready = e1;
  assign in_acc    = in_tvalid && in_tready;

  assign en.shift = in_acc;
  assign en.s1    = e1;
  assign en.s2    = e2;
  assign en.s3    = e3;

  // A restart empties the history; the current sample is then the first one stored.
  // Only a word arriving with four samples already held produces a matrix.
  always_comb begin
    fill_nxt = fill_r;
    v1_nxt   = 1'b0;
    if (in_acc) begin
      if (in_tuser[0]) begin
        fill_nxt = aams_pkg::FILL_W'(1);
      end else if (fill_r != aams_pkg::FILL_FULL) begin
        fill_nxt = fill_r + aams_pkg::FILL_W'(1);
      end else begin
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r  <= aams_pkg::INV_RESET;
      fill_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr[2] == aams_pkg::CFG_IDX_INV)) begin
        inv_r <= cfg_pwdata[aams_pkg::INV_W-1:0];
      end
      fill_r <= fill_nxt;
      if (e1) begin
        v1_r <= v1_nxt;
      end
      if (e2) begin
        v2_r <= v1_r;
      end
      if (e3) begin
        v3_r <= v2_r;
      end
      if (e4) begin
        ov_r <= v3_r;
      end
    end
  end

  // One lane per axis; each lane also forms the product of its rate with the next axis.
  for (genvar a = 0; a < 3; a++) begin : g_lane
    aams_lane #(
      .SAMPLE_WIDTH(SW)
    ) u_lane (
      .clk      (clk),
      .en_i     (en),
      .sample_i (in_tdata[a*SW +: SW]),
      .inv_i    (inv_r),
      .nb_w_i   (w_cent[(a+1)%3]),
      .w_o      (w_cent[a]),
      .dw_o     (dw[a]),
      .sq_o     (sq[a]),
      .cr_o     (cr[a])
    );
  end

  aams_merge #(
    .SAMPLE_WIDTH(SW)
  ) u_merge (
    .clk    (clk),
    .load_i (e4),
    .dw_i   (dw),
    .sq_i   (sq),
    .cr_i   (cr),
    .mat_o  (mat)
  );

  assign out_tdata  = mat;
  assign out_tvalid = ov_r;

endmodule

@@ src/aams_chk.sv @@
// Port-level checker for the angular acceleration matrix block, with its bind statement.
`include "angular_accel_matrix_stream_defines.svh"

module aams_chk (
  input logic                                          clk,
  input logic                                          rst_n,
  input logic                                          in_tready,
  input logic [aams_pkg::NUM_ENT*aams_pkg::ENT_W-1:0]  out_tdata,
  input logic                                          out_tvalid,
  input logic                                          out_tready
);

  // A waiting matrix keeps its value until it is taken.
  `AAMS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")

  // With the output free to drain, nothing in the pipeline may hold up the input.
  `AAMS_ASSERT_NOW(a_in_free, out_tready, in_tready, "input stalled although the output is ready")

  // Diagonal entries are negated sums of squares, so never positive.
  `AAMS_ASSERT_NOW(a_diag_sign, out_tvalid, (out_tdata[39] || out_tdata[39:0] == 40'd0) && (out_tdata[199] || out_tdata[199:160] == 40'd0) && (out_tdata[359] || out_tdata[359:320] == 40'd0), "diagonal entry is positive")

  // Reset leaves the pipeline empty.
  `AAMS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid straight after reset")

endmodule

bind angular_accel_matrix_stream aams_chk u_aams_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

@@ tb/angular_accel_matrix_stream_tb.sv @@
// Self-checking testbench for the angular acceleration matrix stream block.
`timescale 1ns / 100ps

module angular_accel_matrix_stream_tb;

  // Width of one gyro axis, kept at the block's default.
  localparam int SW = aams_pkg::SAMPLE_WIDTH_DEF;
  localparam int IN_W = ((3 * SW + 7) / 8) * 8;
  localparam int INV_W = aams_pkg::INV_W;
  localparam int ENT_W = aams_pkg::ENT_W;
  localparam int NUM_ENT = aams_pkg::NUM_ENT;
  localparam int CFG_AW = aams_pkg::CFG_AW;
  localparam int CFG_DW = aams_pkg::CFG_DW;

  // The scale register is register zero and sits at byte address four times its index.
  localparam logic [CFG_AW-1:0] SCALE_ADDR = CFG_AW'(4 * aams_pkg::CFG_IDX_INV);

  // Extra wait after the pipeline has drained.
  localparam int DRAIN_CYCLES = 8;

  // Between handshakes a correct run sees only the short random gaps on either side, and
  // its longest quiet spell is a drain pause.
  // The watchdog limit is taken well above that.
  localparam int WATCHDOG_LIMIT = 4000;

  localparam longint ENT_MAX = 64'sd549755813887;
  localparam longint ENT_MIN = -64'sd549755813888;
  localparam longint DW_MAX = 64'sd2147483647;
  localparam longint DW_MIN = -64'sd2147483648;

  logic              clk;
  logic              rst_n;
  logic [IN_W-1:0]   in_tdata;
  logic [0:0]        in_tuser;
  logic              in_tvalid;
  logic              in_tready;
  logic [NUM_ENT*ENT_W-1:0] out_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  angular_accel_matrix_stream #(
    .SAMPLE_WIDTH(SW)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Own copy of the block's state: the scale register and the four older samples, oldest
  // first, with the number of them that belong to the current record.
  logic [INV_W-1:0] scale_q = aams_pkg::INV_RESET;
  longint           rate_hist [4][3];
  int               hist_count = 0;

  // Matrices still owed by the block, oldest first.
  aams_pkg::mat_t pending_matrices[$];

  int  mismatches = 0;
  int  words_sent = 0;
  int  restarts_sent = 0;
  int  matrices_checked = 0;
  int  scale_settings = 0;
  bit  word_gaps_on = 1'b1;
  bit  sink_gaps_on = 1'b1;

  // The clock runs with a 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reports the first ten mismatches in full; later ones are only counted.
  task automatic report_mismatch(input string what, input logic [ENT_W-1:0] want,
                                 input logic [ENT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR at %0t: %s expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Five-point stencil on one axis, scaled, rounded half up to 2^-11 and clamped to 32 bits.
  function automatic longint stencil_rate(input longint s0, input longint s1,
                                          input longint s3, input longint s4);
    longint sum;
    longint prod;
    sum = s0 - 8 * s1 + 8 * s3 - s4;
    prod = sum * longint'(scale_q) + 16;
    prod = prod >>> 5;
    if (prod > DW_MAX) begin
      prod = DW_MAX;
    end else if (prod < DW_MIN) begin
      prod = DW_MIN;
    end
    return prod;
  endfunction

  function automatic logic [ENT_W-1:0] clamp_entry(input longint v);
    longint c;
    c = v;
    if (c > ENT_MAX) begin
      c = ENT_MAX;
    end else if (c < ENT_MIN) begin
      c = ENT_MIN;
    end
    return c[ENT_W-1:0];
  endfunction

  // Advances the history by one accepted word. Returns 1 with the expected matrix when the
  // word completes a run of five samples, the centre one of which gives w.
  function automatic bit predict_matrix(input longint cx, input longint cy, input longint cz,
                                        input logic restart, output aams_pkg::mat_t m);
    longint wx, wy, wz, dx, dy, dz;
    int k;
    m = '0;
    if (restart) begin
      hist_count = 0;
    end
    if (hist_count < 4) begin
      rate_hist[hist_count][0] = cx;
      rate_hist[hist_count][1] = cy;
      rate_hist[hist_count][2] = cz;
      hist_count++;
      return 1'b0;
    end
    dx = stencil_rate(rate_hist[0][0], rate_hist[1][0], rate_hist[3][0], cx);
    dy = stencil_rate(rate_hist[0][1], rate_hist[1][1], rate_hist[3][1], cy);
    dz = stencil_rate(rate_hist[0][2], rate_hist[1][2], rate_hist[3][2], cz);
    wx = rate_hist[2][0];
    wy = rate_hist[2][1];
    wz = rate_hist[2][2];
    // skew(dw) + skew(w)^2, row by row.
    m[0] = clamp_entry(-(wy * wy + wz * wz));
    m[1] = clamp_entry(wx * wy - dz);
    m[2] = clamp_entry(dy + wx * wz);
    m[3] = clamp_entry(dz + wx * wy);
    m[4] = clamp_entry(-(wx * wx + wz * wz));
    m[5] = clamp_entry(wy * wz - dx);
    m[6] = clamp_entry(wx * wz - dy);
    m[7] = clamp_entry(dx + wy * wz);
    m[8] = clamp_entry(-(wx * wx + wy * wy));
    for (k = 0; k < 3; k++) begin
      rate_hist[k] = rate_hist[k + 1];
    end
    rate_hist[3][0] = cx;
    rate_hist[3][1] = cy;
    rate_hist[3][2] = cz;
    return 1'b1;
  endfunction

  // Sends one gyro word, with a random gap before it while gaps are on. The word is taken
  // at the first rising edge with tready high; tvalid stays up after it, so that the next
  // call can follow on without a bubble.
  task automatic send_rates(input logic signed [SW-1:0] rx, input logic signed [SW-1:0] ry,
                            input logic signed [SW-1:0] rz, input logic restart);
    aams_pkg::mat_t m;
    @(negedge clk);
    while (word_gaps_on && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rz, ry, rx};
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (restart) begin
      restarts_sent++;
    end
    if (predict_matrix(rx, ry, rz, restart, m)) begin
      pending_matrices.insert(pending_matrices.size(), m);
    end
  endtask

  // Stops the sender and waits until every owed matrix has come, then waits out the extra cycles it is given.
  task automatic hold_until_drained(input int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_scale(input logic [INV_W-1:0] value);
    logic [CFG_DW-INV_W-1:0] junk;
    junk = (CFG_DW-INV_W)'($urandom);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SCALE_ADDR;
    // The bits above the register are filled with noise; the register ignores them.
    cfg_pwdata  <= {junk, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    scale_q = value;
    scale_settings++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Reads the scale register back and compares it with the copy held here.
  task automatic check_scale();
    logic [CFG_DW-1:0] rd;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= SCALE_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[INV_W-1:0] !== scale_q) begin
      report_mismatch("scale readback", ENT_W'(scale_q), ENT_W'(rd[INV_W-1:0]));
    end
  endtask

  // The register is only touched once the pipeline has emptied.
  task automatic set_scale(input logic [INV_W-1:0] value);
    hold_until_drained(DRAIN_CYCLES);
    write_scale(value);
    check_scale();
  endtask

  // Mostly full-range values, with small values and the axis extremes mixed in.
  function automatic logic [SW-1:0] rand_rate();
    int pick;
    logic [SW-1:0] v;
    pick = $urandom_range(99);
    if (pick < 60) begin
      v = SW'($urandom);
    end else if (pick < 85) begin
      v = SW'($urandom_range(511));
      v = v - SW'(256);
    end else begin
      case ($urandom_range(3))
        0: begin
          v = {1'b0, {(SW-1){1'b1}}};
        end
        1: begin
          v = {1'b1, {(SW-1){1'b0}}};
        end
        2: begin
          v = '0;
        end
        default: begin
          v = '1;
        end
      endcase
    end
    return v;
  endfunction

  // The reset value of the scale reads back, and the first words after reset only fill the
  // history.
  task automatic test_default_scale();
    check_scale();
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b0);
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b0);
  endtask

  // Full-scale rates laid out so that the stencil sum reaches both of its extremes and the
  // centre sample sits at either end of the axis range. The y axis mirrors x by inversion.
  task automatic test_full_scale_rates();
    logic signed [SW-1:0] pattern [7];
    int i;
    pattern[0] = {1'b0, {(SW-1){1'b1}}};
    pattern[1] = {1'b1, {(SW-1){1'b0}}};
    pattern[2] = {1'b1, {(SW-1){1'b0}}};
    pattern[3] = {1'b0, {(SW-1){1'b1}}};
    pattern[4] = {1'b1, {(SW-1){1'b0}}};
    pattern[5] = {1'b0, {(SW-1){1'b1}}};
    pattern[6] = {1'b0, {(SW-1){1'b1}}};
    for (i = 0; i < 7; i++) begin
      send_rates(pattern[i], ~pattern[i], pattern[i], 1'b0);
    end
  endtask

  // A restart part way through the filling of a record empties the history; the next
  // record then needs five words of its own before a matrix comes.
  task automatic test_restart_cases();
    int i;
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b1);
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b0);
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b0);
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b1);
    for (i = 0; i < 4; i++) begin
      send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b0);
    end
  endtask

  // A zero scale gives no angular acceleration, the smallest scale barely any, and the
  // largest one is run with x and y alternating between their extremes and random z.
  task automatic test_scale_limits();
    int i;
    set_scale('0);
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b0);
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b0);
    set_scale(INV_W'(1));
    send_rates(rand_rate(), rand_rate(), rand_rate(), 1'b0);
    set_scale('1);
    send_rates({1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}}, '0, 1'b1);
    for (i = 0; i < 5; i++) begin
      if (i[0]) begin
        send_rates({1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}}, rand_rate(), 1'b0);
      end else begin
        send_rates({1'b1, {(SW-1){1'b0}}}, {1'b0, {(SW-1){1'b1}}}, rand_rate(), 1'b0);
      end
    end
  endtask

  // One phase of random traffic under one scale. Records mostly run long enough to give
  // matrices; about one in ten is cut short. A noisy phase adds stray restarts on top.
  task automatic run_random_phase(input logic [INV_W-1:0] scale, input int words,
                                  input bit noisy, input bit pause_midway);
    int left_in_record;
    int i;
    logic restart;
    left_in_record = 0;
    set_scale(scale);
    for (i = 0; i < words; i++) begin
      if (pause_midway && i == words / 2) begin
        hold_until_drained(0);
      end
      restart = 1'b0;
      if (left_in_record == 0) begin
        restart = 1'b1;
        left_in_record = ($urandom_range(9) == 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(5, 80);
      end
      if (noisy && $urandom_range(99) < 25) begin
        restart = 1'b1;
      end
      left_in_record--;
      send_rates(rand_rate(), rand_rate(), rand_rate(), restart);
    end
  endtask

  // Six phases of random words: random, default, smallest-range and largest scales, one
  // phase without any gaps on either side, one noisy phase, and a pause that lets the
  // pipeline empty completely half way through the second.
  task automatic test_random_stream();
    run_random_phase(INV_W'($urandom_range(1, 24'hFFFFFF)), 150, 1'b0, 1'b0);
    run_random_phase(aams_pkg::INV_RESET, 150, 1'b0, 1'b1);
    word_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    run_random_phase(INV_W'($urandom_range(1, 24'hFFFFFF)), 150, 1'b0, 1'b0);
    word_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    run_random_phase('1, 150, 1'b0, 1'b0);
    run_random_phase(INV_W'($urandom_range(1, 255)), 150, 1'b1, 1'b0);
    run_random_phase(INV_W'($urandom_range(1, 24'hFFFFFF)), 150, 1'b0, 1'b0);
  endtask

  // The receiver stalls at random while gaps are on.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= !(sink_gaps_on && $urandom_range(99) < 17);
    end
  end

  // Every matrix taken is compared entry by entry with the oldest one owed.
  always @(posedge clk) begin
    aams_pkg::mat_t got;
    aams_pkg::mat_t want;
    int k;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected matrix, entry m00", '0, got[0]);
      end else begin
        want = pending_matrices.pop_front();
        matrices_checked++;
        for (k = 0; k < NUM_ENT; k++) begin
          if (got[k] !== want[k]) begin
            report_mismatch($sformatf("entry m%0d%0d", k / 3, k % 3), want[k], got[k]);
          end
        end
      end
    end
  end

  // Ends the run when nothing at all has been accepted for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog expired with %0d matrices still owed.", pending_matrices.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_scale();
    test_full_scale_rates();
    test_restart_cases();
    test_scale_limits();
    test_random_stream();

    // Let the last matrices out, and give a stray one time to show itself.
    hold_until_drained(2 * DRAIN_CYCLES);
    mismatches += pending_matrices.size();

    $display("Sent %0d gyro words with %0d restarts under %0d scale settings.",
             words_sent, restarts_sent, scale_settings);
    $display("Checked %0d matrices; %0d mismatches found.", matrices_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/aams_pkg.sv
src/aams_lane.sv
src/aams_merge.sv
src/angular_accel_matrix_stream.sv
src/aams_chk.sv
tb/angular_accel_matrix_stream_tb.sv
